[rtl/core/nand_page_read_sequencer_macros.svh]
// Assertion macros for the NAND page read sequencer.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef NAND_PAGE_READ_SEQUENCER_MACROS_SVH
`define NAND_PAGE_READ_SEQUENCER_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define NPRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define NPRS_NEVER(label, expr, msg) \
    `NPRS_ASSERT(label, !(expr), msg)

`endif

[rtl/core/nprs_pkg.sv]
// Package for the NAND page read sequencer: opcodes, phases, command bytes
// and the result entry type. No dependencies.
`timescale 1ns / 1ps

package nprs_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_READY = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        OP_ENABLE  = 3'd0,
        OP_DISABLE = 3'd1,
        OP_COMMAND = 3'd2,
        OP_ADDRESS = 3'd3,
        OP_READ    = 3'd4,
        OP_STORE   = 3'd5,
        OP_DONE    = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_RESET = 2'd1,
        PH_WAIT_PAGE  = 2'd2,
        PH_READING    = 2'd3
    } phase_t;

    localparam logic [7:0] NAND_CMD_RESET     = 8'hFF;
    localparam logic [7:0] NAND_CMD_READ      = 8'h00;
    localparam logic [7:0] NAND_CMD_READ_CONF = 8'h30;

    typedef struct packed {
        op_t        op;
        logic [7:0] val;
    } ent_t;

    localparam ent_t ENT_NONE = '{op: OP_ENABLE, val: 8'h00};

endpackage

[rtl/core/nand_page_read_sequencer.sv]
// NAND large-page read sequencer: turns start, ready and data beats into a
// stream of flash bus operations. Depends on nprs_pkg and the macro header.
//
// Each accepted input beat is decoded in one pass into a burst of zero to
// eight result beats (enable/reset, page addressing, read command plus read
// request, store plus next read request, disable/done), held in an
// eight-entry burst register that drains one result beat per cycle while
// result_stall is low. A new input beat is taken in the same cycle as the
// last pending result leaves. A data byte normally yields two results
// (store and read request), a page change eight. The single result port
// sets the input rate. PAGE_BYTES must be a power of two; column is its low
// address bits, page the bits above, of which the low 24 are sent.
`timescale 1ns / 1ps
`include "nand_page_read_sequencer_macros.svh"

module nand_page_read_sequencer
    import nprs_pkg::*;
#(
    parameter int PAGE_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] start_address,
    input  logic [31:0] transfer_length,
    input  logic        ready_pin,
    input  logic [7:0]  flash_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  operation,
    output logic [7:0]  bus_value,
    output logic [31:0] dest_offset,
    output logic        last
);

    localparam int PAGE_BITS = $clog2(PAGE_BYTES);

    phase_t             phase_reg,   phase_next;
    logic [31:0]        addr_reg,    addr_next;
    logic [31:0]        done_reg,    done_next;
    logic [31:0]        total_reg,   total_next;

    ent_t               ent_reg [MAX_RESULTS];
    logic [31:0]        off_reg;
    logic [CNT_W-1:0]   cnt_reg;

    ent_t               lst     [MAX_RESULTS];
    ent_t               pg      [7];
    logic [CNT_W-1:0]   lst_n;
    logic [31:0]        lst_off;

    logic               item_acc;
    logic               result_acc;
    logic [31:0]        addr_inc;
    logic [31:0]        done_inc;
    logic [31:0]        addr_src;
    logic [15:0]        col;
    logic [31:0]        page;
    logic               page_end;

    assign item_stall   = (cnt_reg > CNT_W'(1)) || (cnt_reg == CNT_W'(1) && result_stall);
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = (cnt_reg != '0);
    assign result_acc   = result_valid && !result_stall;

    assign operation    = ent_reg[0].op;
    assign bus_value    = ent_reg[0].val;
    assign dest_offset  = off_reg;
    assign last         = (cnt_reg == CNT_W'(1));

    assign addr_inc = addr_reg + 32'd1;
    assign done_inc = done_reg + 32'd1;
    assign page_end = (addr_inc[PAGE_BITS-1:0] == '0);
    assign addr_src = (phase_reg == PH_READING) ? addr_inc : addr_reg;
    assign col      = 16'(addr_src[PAGE_BITS-1:0]);
    assign page     = addr_src >> PAGE_BITS;

    always_comb
    begin
        pg[0] = '{op: OP_COMMAND, val: NAND_CMD_READ};
        pg[1] = '{op: OP_ADDRESS, val: col[7:0]};
        pg[2] = '{op: OP_ADDRESS, val: col[15:8]};
        pg[3] = '{op: OP_ADDRESS, val: page[7:0]};
        pg[4] = '{op: OP_ADDRESS, val: page[15:8]};
        pg[5] = '{op: OP_ADDRESS, val: page[23:16]};
        pg[6] = '{op: OP_COMMAND, val: NAND_CMD_READ_CONF};
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            lst[i] = ENT_NONE;
        end
        lst_n      = '0;
        lst_off    = '0;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        done_next  = done_reg;
        total_next = total_reg;

        unique case (cmd)
            CMD_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    addr_next  = start_address;
                    total_next = transfer_length;
                    done_next  = '0;
                    lst[0]     = '{op: OP_ENABLE, val: 8'h00};
                    lst[1]     = '{op: OP_COMMAND, val: NAND_CMD_RESET};
                    lst_n      = CNT_W'(2);
                    phase_next = PH_WAIT_RESET;
                end
            end
            CMD_READY:
            begin
                if (ready_pin && phase_reg == PH_WAIT_RESET)
                begin
                    if (done_reg == total_reg)
                    begin
                        lst[0]     = '{op: OP_DISABLE, val: 8'h00};
                        lst[1]     = '{op: OP_DONE, val: 8'h00};
                        lst_n      = CNT_W'(2);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            lst[i] = pg[i];
                        end
                        lst_n      = CNT_W'(7);
                        phase_next = PH_WAIT_PAGE;
                    end
                end
                else if (ready_pin && phase_reg == PH_WAIT_PAGE)
                begin
                    lst[0]     = '{op: OP_COMMAND, val: NAND_CMD_READ};
                    lst[1]     = '{op: OP_READ, val: 8'h00};
                    lst_n      = CNT_W'(2);
                    phase_next = PH_READING;
                end
            end
            CMD_DATA:
            begin
                if (phase_reg == PH_READING)
                begin
                    lst[0]    = '{op: OP_STORE, val: flash_byte};
                    lst_off   = done_reg;
                    done_next = done_inc;
                    addr_next = addr_inc;
                    if (done_inc == total_reg)
                    begin
                        lst[1]     = '{op: OP_DISABLE, val: 8'h00};
                        lst[2]     = '{op: OP_DONE, val: 8'h00};
                        lst_n      = CNT_W'(3);
                        phase_next = PH_IDLE;
                    end
                    else if (page_end)
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            lst[i + 1] = pg[i];
                        end
                        lst_n      = CNT_W'(8);
                        phase_next = PH_WAIT_PAGE;
                    end
                    else
                    begin
                        lst[1] = '{op: OP_READ, val: 8'h00};
                        lst_n  = CNT_W'(2);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            done_reg  <= '0;
            total_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (item_acc)
            begin
                phase_reg <= phase_next;
                addr_reg  <= addr_next;
                done_reg  <= done_next;
                total_reg <= total_next;
                cnt_reg   <= lst_n;
            end
            else if (result_acc)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                ent_reg[i] <= lst[i];
            end
            off_reg <= lst_off;
        end
        else if (result_acc)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                ent_reg[i] <= ent_reg[i + 1];
            end
            ent_reg[MAX_RESULTS - 1] <= ENT_NONE;
            off_reg                  <= '0;
        end
    end

    `NPRS_NEVER(a_cnt_range, cnt_reg > CNT_W'(MAX_RESULTS), "burst count out of range")
    `NPRS_ASSERT(a_no_overrun, item_acc |-> cnt_reg <= CNT_W'(1), "beat taken over a pending burst")
    `NPRS_ASSERT(a_store_first, item_acc && cmd == CMD_DATA && phase_reg == PH_READING |=> result_valid && ent_reg[0].op == OP_STORE, "data beat did not lead with a store")
    `NPRS_ASSERT(a_done_last, result_valid && ent_reg[0].op == OP_DONE |-> last, "done is not the last result")

endmodule

[test/tb_nand_page_read_sequencer.sv]
// Self-checking testbench for nand_page_read_sequencer: directed and random
// start/ready/data beats against a behavioral predictor of the bus operations.
// Depends on nprs_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_nand_page_read_sequencer;
    import nprs_pkg::*;

    localparam int PAGE_BYTES   = 2048;
    localparam int ITEM_TARGET  = 245;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        op_t         op;
        logic [7:0]  val;
        logic [31:0] off;
        logic        last;
    } bus_op_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  cmd;
    logic [31:0] start_address;
    logic [31:0] transfer_length;
    logic        ready_pin;
    logic [7:0]  flash_byte;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  operation;
    logic [7:0]  bus_value;
    logic [31:0] dest_offset;
    logic        last;

    nand_page_read_sequencer #(
        .PAGE_BYTES      (PAGE_BYTES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .cmd             (cmd),
        .start_address   (start_address),
        .transfer_length (transfer_length),
        .ready_pin       (ready_pin),
        .flash_byte      (flash_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .operation       (operation),
        .bus_value       (bus_value),
        .dest_offset     (dest_offset),
        .last            (last)
    );

    // predictor state
    phase_t      seq_phase = PH_IDLE;
    logic [31:0] seq_addr  = '0;
    logic [31:0] seq_done  = '0;
    logic [31:0] seq_total = '0;

    bus_op_t     burst_ops[$];
    bus_op_t     expected_bus_ops[$];
    bus_op_t     want;
    int          sent_beats = 0;
    int          mismatches = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_cycle = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic add_op(input op_t op, input logic [7:0] val, input logic [31:0] off);
        bus_op_t e;
        e.op   = op;
        e.val  = val;
        e.off  = off;
        e.last = 1'b0;
        burst_ops.push_back(e);
    endtask

    task automatic add_page_address();
        logic [31:0] col;
        logic [31:0] page;
        col  = seq_addr % 32'(PAGE_BYTES);
        page = seq_addr / 32'(PAGE_BYTES);
        add_op(OP_COMMAND, NAND_CMD_READ, '0);
        add_op(OP_ADDRESS, col[7:0], '0);
        add_op(OP_ADDRESS, col[15:8], '0);
        add_op(OP_ADDRESS, page[7:0], '0);
        add_op(OP_ADDRESS, page[15:8], '0);
        add_op(OP_ADDRESS, page[23:16], '0);
        add_op(OP_COMMAND, NAND_CMD_READ_CONF, '0);
        seq_phase = PH_WAIT_PAGE;
    endtask

    task automatic add_finish();
        add_op(OP_DISABLE, '0, '0);
        add_op(OP_DONE, '0, '0);
        seq_phase = PH_IDLE;
    endtask

    task automatic predict_bus_ops(input logic [1:0] c, input logic [31:0] addr,
                                   input logic [31:0] len, input logic rdy,
                                   input logic [7:0] data);
        bus_op_t tail;
        burst_ops.delete();
        sent_beats++;
        case (c)
            CMD_START:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    seq_addr  = addr;
                    seq_total = len;
                    seq_done  = '0;
                    add_op(OP_ENABLE, '0, '0);
                    add_op(OP_COMMAND, NAND_CMD_RESET, '0);
                    seq_phase = PH_WAIT_RESET;
                end
            end
            CMD_READY:
            begin
                if (rdy && seq_phase == PH_WAIT_RESET)
                begin
                    if (seq_done == seq_total)
                        add_finish();
                    else
                        add_page_address();
                end
                else if (rdy && seq_phase == PH_WAIT_PAGE)
                begin
                    add_op(OP_COMMAND, NAND_CMD_READ, '0);
                    add_op(OP_READ, '0, '0);
                    seq_phase = PH_READING;
                end
            end
            CMD_DATA:
            begin
                if (seq_phase == PH_READING)
                begin
                    add_op(OP_STORE, data, seq_done);
                    seq_done = seq_done + 1;
                    seq_addr = seq_addr + 1;
                    if (seq_done == seq_total)
                        add_finish();
                    else if (seq_addr % 32'(PAGE_BYTES) == 0)
                        add_page_address();
                    else
                        add_op(OP_READ, '0, '0);
                end
            end
            default: ;
        endcase
        if (burst_ops.size() > 0)
        begin
            tail = burst_ops[burst_ops.size() - 1];
            tail.last = 1'b1;
            burst_ops[burst_ops.size() - 1] = tail;
        end
        foreach (burst_ops[i])
            expected_bus_ops.push_back(burst_ops[i]);
    endtask

    // sender: bursts of random length, random gaps between them
    task automatic send_beat(input logic [1:0] c, input logic [31:0] addr,
                             input logic [31:0] len, input logic rdy,
                             input logic [7:0] data);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_valid      <= 1'b1;
        cmd             <= c;
        start_address   <= addr;
        transfer_length <= len;
        ready_pin       <= rdy;
        flash_byte      <= data;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_bus_ops(c, addr, len, rdy, data);
    endtask

    task automatic send_start(input logic [31:0] addr, input logic [31:0] len);
        send_beat(CMD_START, addr, len, 1'($urandom), 8'($urandom));
    endtask

    task automatic send_ready(input logic rdy);
        send_beat(CMD_READY, $urandom, $urandom, rdy, 8'($urandom));
    endtask

    task automatic send_data(input logic [7:0] data);
        send_beat(CMD_DATA, $urandom, $urandom, 1'($urandom), data);
    endtask

    // idle noise never carries a start
    task automatic send_noise(input bit idle);
        send_beat(2'($urandom_range(idle ? 1 : 0, 3)), $urandom, $urandom,
                  1'($urandom), 8'($urandom));
    endtask

    task automatic test_basic_read();
        send_start(32'h0000_0100, 32'd2);
        send_ready(1'b0);
        send_ready(1'b1);
        send_ready(1'b1);
        send_data(8'h00);
        send_data(8'hFF);
    endtask

    // last byte of the address space: page change and address wrap
    task automatic test_page_wrap();
        send_start(32'hFFFF_FFFF, 32'd2);
        send_ready(1'b1);
        send_ready(1'b1);
        send_data(8'hA5);
        send_ready(1'b1);
        send_data(8'h5A);
    endtask

    task automatic test_ignored_and_zero_length();
        send_ready(1'b1);
        send_data(8'h3C);
        send_beat(CMD_UNUSED, $urandom, $urandom, 1'b1, 8'($urandom));
        send_start(32'h0000_0800, 32'd0);
        send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_data(8'hC3);
        send_ready(1'b0);
        send_ready(1'b1);
    endtask

    task automatic test_random_reads();
        logic [31:0] addr;
        logic [31:0] len;
        while (sent_beats < ITEM_TARGET)
        begin
            if ($urandom_range(0, 1) == 0)
                addr = ($urandom & ~32'(PAGE_BYTES - 1)) + 32'(PAGE_BYTES)
                       - $urandom_range(1, 8);
            else
                addr = $urandom;
            len = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
            if ($urandom_range(0, 3) == 0)
                send_noise(1'b1);
            send_start(addr, len);
            while (seq_phase != PH_IDLE)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise(1'b0);
                else if (seq_phase == PH_READING)
                    send_data(8'($urandom));
                else
                    send_ready($urandom_range(0, 3) != 0);
            end
        end
    endtask

    // full-scale length; the transfer is left open at the end of the run
    task automatic test_long_length();
        send_start($urandom, 32'hFFFF_FFFF);
        send_ready(1'b1);
        send_ready(1'b1);
        repeat (3) send_data(8'($urandom));
    endtask

    // receiver stall pattern cycles through several modes
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_cycle++;
            case ((stall_cycle / 97) % 4)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 2) == 0);
                2: result_stall <= ((stall_cycle % 5) < 2);
                default: result_stall <= 1'($urandom);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bus_ops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: op=%0d val=%h off=%h last=%b",
                             operation, bus_value, dest_offset, last);
            end
            else
            begin
                want = expected_bus_ops.pop_front();
                if (operation !== want.op || bus_value !== want.val ||
                    dest_offset !== want.off || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 want.op, want.val, want.off, want.last,
                                 operation, bus_value, dest_offset, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        cmd             = CMD_START;
        start_address   = '0;
        transfer_length = '0;
        ready_pin       = 1'b0;
        flash_byte      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_read();
        test_page_wrap();
        test_ignored_and_zero_length();
        test_random_reads();
        test_long_length();

        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_bus_ops.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_bus_ops.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
